[rtl/ffa_pkg.sv]
// Shared constants and types for the first-fit free-list allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;

    // Pool geometry.
    localparam int POOL_UNITS  = 16384;
    localparam int IDX_W       = $clog2(POOL_UNITS);
    localparam int SIZE_W      = IDX_W + 1;
    localparam int UNIT_BYTES  = 16;
    localparam int UNIT_SHIFT  = $clog2(UNIT_BYTES);

    // Field widths.
    localparam int BYTES_W     = 20;
    localparam int COUNT_W     = 16;
    localparam int PROD_W      = 2 * COUNT_W;
    localparam int UNITS_W     = BYTES_W - UNIT_SHIFT + 1;
    localparam int MINGROW_W   = 15;
    localparam int STATUS_W    = 3;

    // Walk bounds for a damaged list.
    localparam int ALLOC_LIMIT = 4 * POOL_UNITS + 8;
    localparam int REL_LIMIT   = POOL_UNITS + 2;
    localparam int ASTEP_W     = $clog2(ALLOC_LIMIT + 1);
    localparam int RSTEP_W     = $clog2(REL_LIMIT + 1);

    // Request kinds.
    typedef enum logic [1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_CALLOC = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    // Result codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOC = 3'd0,
        ST_FREED = 3'd1,
        ST_BIG   = 3'd2,
        ST_POOL  = 3'd3,
        ST_NULL  = 3'd4,
        ST_BADSZ = 3'd5
    } status_t;

    // Configuration register indexes.
    localparam logic CFG_MAX_BYTES = 1'b0;
    localparam logic CFG_MIN_GROW  = 1'b1;

endpackage
`default_nettype wire

[rtl/ffa_ram.sv]
// Simple dual-port synchronous RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ffa_ram #(
    parameter int WIDTH  = ffa_pkg::SIZE_W,
    parameter int ADDR_W = ffa_pkg::IDX_W
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [2**ADDR_W];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data registered in the cycle after the address.
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

[rtl/first_fit_free_list_allocator_core.sv]
// Top level of the first-fit free-list allocator: request sequencer and header stores.
//
//  Channel  | Direction | Transaction contents
//  s_       | in        | tuser: mode; tdata: byte_count, item_count, item_size, block_index
//  m_       | out       | tuser: status; tdata: payload_index
//  cfg_     | in        | write of max_bytes (index 0) or min_grow_units (index 1)
//
// An allocation checks the size, reads a next link and evaluates one list node per step,
// plus a split step for a partial fit and a multiply step for calloc; a growth adds a walk
// and merge steps. A free reads the size, walks and merges; one read address sets the pace.
// A clearing pass over all 16384 headers after reset zeroes the stores; no request is
// accepted meanwhile. Reset is synchronous and active low. A finished result waits in the
// output register while the next request is taken; a stalled output holds the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_free_list_allocator_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,  // byte_count, item_count, item_size, block_index
    input  wire logic [1:0]  s_tuser,  // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,  // payload_index
    output logic [2:0]       m_tuser,  // status
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [19:0] cfg_wdata
);
    import ffa_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MUL, S_ACHK, S_APNEXT, S_AEVAL, S_ASPLIT, S_AGROWN,
        S_FSZ, S_RWALK, S_RRDN, S_RRDP, S_RW2, S_RESP
    } state_t;

    localparam logic [SIZE_W-1:0]  POOL_SZ = SIZE_W'(POOL_UNITS);
    localparam logic [ASTEP_W-1:0] A_LIM   = ASTEP_W'(ALLOC_LIMIT);
    localparam logic [RSTEP_W-1:0] R_LIM   = RSTEP_W'(REL_LIMIT);

    state_t               state_reg;
    logic [IDX_W-1:0]     clr_reg;
    logic [BYTES_W-1:0]   max_bytes_reg;
    logic [MINGROW_W-1:0] min_grow_reg;
    logic [IDX_W-1:0]     rover_reg;
    logic [SIZE_W-1:0]    bp_reg;
    logic [SIZE_W-1:0]    lg_reg;
    logic [COUNT_W-1:0]   icnt_reg;
    logic [COUNT_W-1:0]   isize_reg;
    logic [PROD_W-1:0]    nbytes_reg;
    logic [UNITS_W-1:0]   units_reg;
    logic [IDX_W-1:0]     prev_reg;
    logic [IDX_W-1:0]     p_reg;
    logic [IDX_W-1:0]     split_reg;
    logic [ASTEP_W-1:0]   astep_reg;
    logic [RSTEP_W-1:0]   rstep_reg;
    logic                 grow_reg;
    logic [IDX_W-1:0]     h_reg;
    logic [SIZE_W-1:0]    hsz_reg;
    logic [IDX_W-1:0]     rp_reg;
    logic [IDX_W-1:0]     rn_reg;
    logic [SIZE_W-1:0]    sizen_reg;
    logic [IDX_W-1:0]     nextn_reg;
    logic [SIZE_W-1:0]    sizep_reg;
    logic [SIZE_W-1:0]    hs2_reg;
    logic [IDX_W-1:0]     hn2_reg;
    logic [STATUS_W-1:0]  st_reg;
    logic [IDX_W-1:0]     pay_reg;
    logic                 m_tvalid_reg;
    logic [IDX_W-1:0]     m_pay_reg;
    logic [STATUS_W-1:0]  m_st_reg;

    // Header store ports.
    logic               size_we, next_we;
    logic [IDX_W-1:0]   size_wa, next_wa, rd_addr;
    logic [SIZE_W-1:0]  size_wd, size_rd;
    logic [IDX_W-1:0]   next_wd, next_rd;

    // Request fields.
    logic [1:0]         in_mode;
    logic [BYTES_W-1:0] in_bytes;
    logic [COUNT_W-1:0] in_icnt, in_isize;
    logic [IDX_W-1:0]   in_block;

    assign in_mode  = s_tuser;
    assign in_bytes = s_tdata[19:0];
    assign in_icnt  = s_tdata[35:20];
    assign in_isize = s_tdata[51:36];
    assign in_block = s_tdata[65:52];

    // Allocation step terms.
    logic [UNITS_W-1:0] units_calc, grow_units;
    logic               fits, exact, grow_fail, walk_break, merge_hi, merge_lo;
    logic [SIZE_W-1:0]  remain, rem_pool;
    logic [SIZE_W:0]    h_end, p_end;

    assign units_calc = UNITS_W'(({1'b0, nbytes_reg[BYTES_W-1:0]}
                                  + (BYTES_W + 1)'(UNIT_BYTES - 1)) >> UNIT_SHIFT)
                        + UNITS_W'(1);
    assign fits       = UNITS_W'(size_rd) >= units_reg;
    assign exact      = UNITS_W'(size_rd) == units_reg;
    assign remain     = size_rd - SIZE_W'(units_reg);
    assign grow_units = (units_reg < UNITS_W'(min_grow_reg)) ? UNITS_W'(min_grow_reg)
                                                             : units_reg;
    assign rem_pool   = POOL_SZ - bp_reg;
    assign grow_fail  = grow_units > UNITS_W'(rem_pool);

    // Release insertion point and neighbour merges.
    assign walk_break = ((rp_reg < h_reg) && (h_reg < next_rd)) ||
                        ((rp_reg >= next_rd) && ((rp_reg < h_reg) || (h_reg < next_rd)));
    assign h_end      = (SIZE_W + 1)'(h_reg) + (SIZE_W + 1)'(hsz_reg);
    assign merge_hi   = h_end == (SIZE_W + 1)'(rn_reg);
    assign p_end      = (SIZE_W + 1)'(rp_reg) + (SIZE_W + 1)'(sizep_reg);
    assign merge_lo   = p_end == (SIZE_W + 1)'(h_reg);

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = 16'(m_pay_reg);
    assign m_tuser  = m_st_reg;

    // Header store access per state.
    always_comb begin
        size_we = 1'b0;
        size_wa = p_reg;
        size_wd = '0;
        next_we = 1'b0;
        next_wa = p_reg;
        next_wd = '0;
        rd_addr = next_rd;
        unique case (state_reg)
            S_CLEAR: begin
                size_we = 1'b1;
                size_wa = clr_reg;
                next_we = 1'b1;
                next_wa = clr_reg;
            end
            S_IDLE:   rd_addr = in_block - IDX_W'(1);
            S_ACHK:   rd_addr = rover_reg;
            S_AGROWN: rd_addr = rover_reg;
            S_FSZ:    rd_addr = rover_reg;
            S_RRDN:   rd_addr = rp_reg;
            S_AEVAL: begin
                if (fits && exact) begin
                    next_we = 1'b1;
                    next_wa = prev_reg;
                    next_wd = next_rd;
                end else if (fits) begin
                    size_we = 1'b1;
                    size_wa = p_reg;
                    size_wd = remain;
                end else if (p_reg == rover_reg && !grow_fail) begin
                    size_we = 1'b1;
                    size_wa = bp_reg[IDX_W-1:0];
                    size_wd = SIZE_W'(grow_units);
                    rd_addr = rover_reg;
                end
            end
            S_ASPLIT: begin
                size_we = 1'b1;
                size_wa = split_reg;
                size_wd = SIZE_W'(units_reg);
            end
            S_RRDP: begin
                size_we = merge_hi;
                size_wa = h_reg;
                size_wd = hsz_reg + sizen_reg;
                next_we = 1'b1;
                next_wa = h_reg;
                next_wd = merge_hi ? nextn_reg : rn_reg;
            end
            S_RW2: begin
                size_we = merge_lo;
                size_wa = rp_reg;
                size_wd = sizep_reg + hs2_reg;
                next_we = 1'b1;
                next_wa = rp_reg;
                next_wd = merge_lo ? hn2_reg : h_reg;
            end
            default: rd_addr = next_rd;
        endcase
    end

    // Size field of every header.
    ffa_ram #(.WIDTH(SIZE_W), .ADDR_W(IDX_W)) u_size_ram (
        .aclk    (aclk),
        .wr_en   (size_we),
        .wr_addr (size_wa),
        .wr_data (size_wd),
        .rd_addr (rd_addr),
        .rd_data (size_rd)
    );

    // Next-link field of every header.
    ffa_ram #(.WIDTH(IDX_W), .ADDR_W(IDX_W)) u_next_ram (
        .aclk    (aclk),
        .wr_en   (next_we),
        .wr_addr (next_wa),
        .wr_data (next_wd),
        .rd_addr (rd_addr),
        .rd_data (next_rd)
    );

    // Sequencer, configuration and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            max_bytes_reg <= BYTES_W'(10240);
            min_grow_reg  <= MINGROW_W'(1024);
            rover_reg     <= '0;
            bp_reg        <= SIZE_W'(1);
            lg_reg        <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_MAX_BYTES: max_bytes_reg <= cfg_wdata;
                    CFG_MIN_GROW:  min_grow_reg  <= cfg_wdata[MINGROW_W-1:0];
                    default:       max_bytes_reg <= max_bytes_reg;
                endcase
            end
            // The response state reloads the output register itself.
            if (m_tvalid_reg && m_tready && state_reg != S_RESP) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + IDX_W'(1);
                    if (clr_reg == {IDX_W{1'b1}}) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        icnt_reg   <= in_icnt;
                        isize_reg  <= in_isize;
                        nbytes_reg <= PROD_W'(in_bytes);
                        h_reg      <= in_block - IDX_W'(1);
                        pay_reg    <= '0;
                        unique case (mode_t'(in_mode))
                            MODE_ALLOC:  state_reg <= S_ACHK;
                            MODE_CALLOC: state_reg <= S_MUL;
                            MODE_FREE: begin
                                if (in_block == '0) begin
                                    st_reg    <= ST_NULL;
                                    state_reg <= S_RESP;
                                end else begin
                                    state_reg <= S_FSZ;
                                end
                            end
                            default: begin
                                st_reg    <= ST_NULL;
                                state_reg <= S_RESP;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    nbytes_reg <= icnt_reg * isize_reg;
                    state_reg  <= S_ACHK;
                end
                S_ACHK: begin
                    if (nbytes_reg > PROD_W'(max_bytes_reg)) begin
                        st_reg    <= ST_BIG;
                        state_reg <= S_RESP;
                    end else begin
                        units_reg <= units_calc;
                        prev_reg  <= rover_reg;
                        astep_reg <= '0;
                        state_reg <= S_APNEXT;
                    end
                end
                S_APNEXT: begin
                    p_reg     <= next_rd;
                    state_reg <= S_AEVAL;
                end
                S_AEVAL: begin
                    if (fits) begin
                        rover_reg <= prev_reg;
                        st_reg    <= ST_ALLOC;
                        if (exact) begin
                            pay_reg   <= p_reg + IDX_W'(1);
                            state_reg <= S_RESP;
                        end else begin
                            split_reg <= p_reg + remain[IDX_W-1:0];
                            state_reg <= S_ASPLIT;
                        end
                    end else if (p_reg == rover_reg) begin
                        if (grow_fail) begin
                            st_reg    <= ST_POOL;
                            state_reg <= S_RESP;
                        end else begin
                            h_reg     <= bp_reg[IDX_W-1:0];
                            hsz_reg   <= SIZE_W'(grow_units);
                            bp_reg    <= bp_reg + SIZE_W'(grow_units);
                            if (SIZE_W'(grow_units) > lg_reg) begin
                                lg_reg <= SIZE_W'(grow_units);
                            end
                            grow_reg  <= 1'b1;
                            rp_reg    <= rover_reg;
                            rstep_reg <= '0;
                            state_reg <= S_RWALK;
                        end
                    end else if (astep_reg >= A_LIM) begin
                        st_reg    <= ST_POOL;
                        state_reg <= S_RESP;
                    end else begin
                        astep_reg <= astep_reg + ASTEP_W'(1);
                        prev_reg  <= p_reg;
                        p_reg     <= next_rd;
                    end
                end
                S_ASPLIT: begin
                    pay_reg   <= split_reg + IDX_W'(1);
                    state_reg <= S_RESP;
                end
                S_AGROWN: begin
                    if (astep_reg >= A_LIM) begin
                        st_reg    <= ST_POOL;
                        state_reg <= S_RESP;
                    end else begin
                        astep_reg <= astep_reg + ASTEP_W'(1);
                        prev_reg  <= rover_reg;
                        state_reg <= S_APNEXT;
                    end
                end
                S_FSZ: begin
                    if (size_rd == '0 || size_rd > lg_reg) begin
                        st_reg    <= ST_BADSZ;
                        state_reg <= S_RESP;
                    end else begin
                        hsz_reg   <= size_rd;
                        grow_reg  <= 1'b0;
                        rp_reg    <= rover_reg;
                        rstep_reg <= '0;
                        state_reg <= S_RWALK;
                    end
                end
                S_RWALK: begin
                    if (walk_break) begin
                        rn_reg    <= next_rd;
                        state_reg <= S_RRDN;
                    end else if (rstep_reg >= R_LIM) begin
                        st_reg    <= grow_reg ? ST_POOL : ST_BADSZ;
                        state_reg <= S_RESP;
                    end else begin
                        rstep_reg <= rstep_reg + RSTEP_W'(1);
                        rp_reg    <= next_rd;
                    end
                end
                S_RRDN: begin
                    sizen_reg <= size_rd;
                    nextn_reg <= next_rd;
                    state_reg <= S_RRDP;
                end
                S_RRDP: begin
                    sizep_reg <= size_rd;
                    hs2_reg   <= merge_hi ? hsz_reg + sizen_reg : hsz_reg;
                    hn2_reg   <= merge_hi ? nextn_reg : rn_reg;
                    state_reg <= S_RW2;
                end
                S_RW2: begin
                    rover_reg <= rp_reg;
                    if (grow_reg) begin
                        state_reg <= S_AGROWN;
                    end else begin
                        st_reg    <= ST_FREED;
                        state_reg <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_pay_reg    <= pay_reg;
                        m_st_reg     <= st_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[tb/first_fit_free_list_allocator_core_checker.sv]
// Checker for the free-list allocator: predicts every result and compares the output channel.
`timescale 1ns / 1ps
module first_fit_free_list_allocator_core_checker
    import ffa_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [71:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic [2:0]  m_tuser,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [19:0] cfg_wdata,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        status_t     status;
        logic [15:0] payload;
    } alloc_result_t;

    // Shadow copy of the allocator state.
    int unsigned   hdr_next [POOL_UNITS];
    int unsigned   hdr_size [POOL_UNITS];
    int unsigned   rover;
    bit            list_ready;
    int unsigned   break_point;
    int unsigned   largest_grow;
    int unsigned   max_bytes;
    int unsigned   min_grow;
    alloc_result_t awaited [$];

    function automatic int unsigned nxt(int unsigned i);
        return (i < POOL_UNITS) ? hdr_next[i] : 0;
    endfunction

    function automatic int unsigned siz(int unsigned i);
        return (i < POOL_UNITS) ? hdr_size[i] : 0;
    endfunction

    function automatic void set_next(int unsigned i, int unsigned v);
        if (i < POOL_UNITS) hdr_next[i] = v;
    endfunction

    function automatic void set_size(int unsigned i, int unsigned v);
        if (i < POOL_UNITS) hdr_size[i] = v;
    endfunction

    // Insert a block into the address-ordered list, merging with both neighbours.
    function automatic status_t insert_block(int unsigned h);
        int unsigned sz;
        int unsigned p;
        int unsigned n;
        longint unsigned steps;
        sz = siz(h);
        p = rover;
        steps = 0;
        if (h >= POOL_UNITS || sz == 0 || sz > largest_grow) return ST_BADSZ;
        forever begin
            n = nxt(p);
            if (p < h && h < n) break;
            if (p >= n && (p < h || h < n)) break;
            steps++;
            if (steps > REL_LIMIT) return ST_BADSZ;
            p = n;
        end
        n = nxt(p);
        if (longint'(h) + sz == n) begin
            set_size(h, sz + siz(n));
            set_next(h, nxt(n));
        end else begin
            set_next(h, n);
        end
        if (longint'(p) + siz(p) == h) begin
            set_size(p, siz(p) + siz(h));
            set_next(p, nxt(h));
        end else begin
            set_next(p, h);
        end
        rover = p;
        return ST_FREED;
    endfunction

    // Take fresh units from the pool and release them into the list.
    function automatic bit extend_pool(longint unsigned units);
        longint unsigned nu;
        int unsigned up;
        nu = (units < min_grow) ? min_grow : units;
        if (nu > longint'(POOL_UNITS) - break_point) return 1'b0;
        up = break_point;
        set_size(up, int'(nu));
        break_point += int'(nu);
        if (int'(nu) > largest_grow) largest_grow = int'(nu);
        return insert_block(up) == ST_FREED;
    endfunction

    // First-fit search from the rover, splitting from the top of the block.
    function automatic status_t take_block(longint unsigned nbytes, output logic [13:0] pay);
        longint unsigned units;
        longint unsigned steps;
        int unsigned prev;
        int unsigned p;
        int unsigned sz;
        pay = '0;
        steps = 0;
        if (nbytes > max_bytes) return ST_BIG;
        units = (nbytes + UNIT_BYTES - 1) / UNIT_BYTES + 1;
        if (!list_ready) begin
            set_next(0, 0);
            set_size(0, 0);
            rover = 0;
            list_ready = 1'b1;
        end
        prev = rover;
        p = nxt(prev);
        forever begin
            sz = siz(p);
            if (sz >= units) begin
                if (sz == units) begin
                    set_next(prev, nxt(p));
                end else begin
                    sz -= int'(units);
                    set_size(p, sz);
                    p += sz;
                    set_size(p, int'(units));
                end
                rover = prev;
                pay = 14'(p + 1);
                return ST_ALLOC;
            end
            if (p == rover) begin
                if (!extend_pool(units)) return ST_POOL;
                p = rover;
            end
            steps++;
            if (steps > ALLOC_LIMIT) return ST_POOL;
            prev = p;
            p = nxt(p);
        end
    endfunction

    function automatic alloc_result_t predict_request(logic [1:0] kind, logic [71:0] d);
        alloc_result_t r;
        logic [13:0] pay;
        logic [13:0] idx;
        pay = '0;
        r.status = ST_NULL;
        case (mode_t'(kind))
            MODE_ALLOC: begin
                r.status = take_block(longint'(d[19:0]), pay);
            end
            MODE_CALLOC: begin
                r.status = take_block(longint'(d[35:20]) * longint'(d[51:36]), pay);
            end
            MODE_FREE: begin
                idx = d[65:52];
                if (idx != 0) r.status = insert_block(idx - 1);
            end
            default: ;
        endcase
        r.payload = {2'b00, pay};
        return r;
    endfunction

    assign pending = awaited.size();

    // Follow configuration writes and both channels at every clock edge.
    always @(posedge aclk) begin
        alloc_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < POOL_UNITS; i++) begin
                hdr_next[i] = 0;
                hdr_size[i] = 0;
            end
            rover = 0;
            list_ready = 1'b0;
            break_point = 1;
            largest_grow = 0;
            max_bytes = 10240;
            min_grow = 1024;
            awaited.delete();
            fail_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_MAX_BYTES) max_bytes = cfg_wdata;
                else min_grow = cfg_wdata[MINGROW_W-1:0];
            end
            // The result of this edge always belongs to an earlier request.
            if (m_tvalid && m_tready) begin
                if (awaited.size() == 0) begin
                    if (fail_count < 10)
                        $display("Unexpected result transaction: status %0d payload %0d",
                                 m_tuser, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = awaited.pop_front();
                    if (m_tuser !== want.status || m_tdata !== want.payload) begin
                        if (fail_count < 10)
                            $display("Mismatch: expected status %0d payload %0d, got %0d %0d",
                                     want.status, want.payload, m_tuser, m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) awaited.push_back(predict_request(s_tuser, s_tdata));
        end
    end

endmodule

[tb/first_fit_free_list_allocator_core_test.sv]
// Testbench top for the free-list allocator: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module first_fit_free_list_allocator_core_test;
    import ffa_pkg::*;

    localparam int QUIET_LIMIT = 400000;
    localparam int PHASE_ITEMS = 226;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [19:0] cfg_wdata = '0;
    int          fail_count;
    int          pending;

    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 1'b0;
    int          quiet_cycles = 0;
    logic [13:0] live_blocks [$];

    first_fit_free_list_allocator_core DUT (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .cfg_wr_en, .cfg_index, .cfg_wdata
    );

    first_fit_free_list_allocator_core_checker checker_i (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .cfg_wr_en, .cfg_index, .cfg_wdata,
        .fail_count, .pending
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver readiness, random or held off entirely.
    always @(posedge aclk) begin
        m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Remember granted blocks so that most frees are of real allocations.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready && m_tuser == ST_ALLOC)
            live_blocks.push_back(m_tdata[13:0]);
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", pending);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request, with random idle cycles ahead of it.
    task automatic send_request(mode_t kind, logic [71:0] data);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_fields(mode_t kind, logic [19:0] nbytes, logic [15:0] cnt,
                               logic [15:0] sz, logic [13:0] idx);
        send_request(kind, {6'b0, idx, sz, cnt, nbytes});
    endtask

    // Stop offering and wait until every result has been taken and recorded.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // Wait for the block to drain, then write both registers.
    task automatic set_registers(logic [19:0] max_b, logic [19:0] grow);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MAX_BYTES;
        cfg_wdata <= max_b;
        @(posedge aclk);
        cfg_index <= CFG_MIN_GROW;
        cfg_wdata <= grow;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly frees of live blocks and modest allocations, with some noise.
    task automatic random_request();
        int pick;
        int slot;
        logic [71:0] junk;
        logic [13:0] idx;
        pick = $urandom_range(99);
        junk = 72'({$urandom, $urandom, $urandom});
        if (pick < 1) begin
            send_request(MODE_FREE, junk);
        end else if (pick < 4) begin
            send_request(MODE_NONE, junk);
        end else if (pick < 46 && live_blocks.size() != 0) begin
            slot = $urandom_range(live_blocks.size() - 1);
            idx = live_blocks[slot];
            live_blocks.delete(slot);
            junk[65:52] = idx;
            send_request(MODE_FREE, junk);
        end else if (pick < 80) begin
            junk[19:0] = ($urandom_range(19) == 0) ? junk[19:0] : 20'($urandom_range(400));
            send_request(MODE_ALLOC, junk);
        end else begin
            if ($urandom_range(9) != 0) begin
                junk[35:20] = 16'($urandom_range(24));
                junk[51:36] = 16'($urandom_range(48));
            end
            send_request(MODE_CALLOC, junk);
        end
    endtask

    // Long receiver hold-off while the sender keeps offering requests.
    initial begin
        wait (send_gap_pct == 1);
        hold_off = 1'b1;
        repeat (400) @(posedge aclk);
        hold_off = 1'b0;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: boundaries, every mode and the special cases.
        send_fields(MODE_FREE, 0, 0, 0, 14'd5);        // free before any growth
        send_fields(MODE_FREE, 0, 0, 0, 14'd0);        // null free
        send_fields(MODE_NONE, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 14'h3FFF);
        send_fields(MODE_ALLOC, 20'd0, 0, 0, 0);       // header-only block, first use
        send_fields(MODE_ALLOC, 20'd1, 0, 0, 0);
        send_fields(MODE_ALLOC, 20'd16, 0, 0, 0);
        send_fields(MODE_ALLOC, 20'd17, 0, 0, 0);
        send_fields(MODE_ALLOC, 20'd10240, 0, 0, 0);
        send_fields(MODE_ALLOC, 20'd10241, 0, 0, 0);
        send_fields(MODE_ALLOC, 20'hFFFFF, 0, 0, 0);
        send_fields(MODE_CALLOC, 0, 16'hFFFF, 16'hFFFF, 0);   // wide product
        send_fields(MODE_CALLOC, 0, 16'd0, 16'd77, 0);
        send_fields(MODE_CALLOC, 0, 16'd101, 16'd101, 0);
        send_fields(MODE_CALLOC, 0, 16'd100, 16'd103, 0);
        send_fields(MODE_FREE, 0, 0, 0, 14'h3FFF);     // unallocated header
        send_fields(MODE_FREE, 0, 0, 0, 14'd1);
        drain();
        while (live_blocks.size() != 0)
            send_fields(MODE_FREE, 0, 0, 0, live_blocks.pop_front());

        // Random phases, each with its own register setting and idling.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_registers(20'd10240, 20'd1024);
                1: set_registers(20'hFFFFF, 20'd1);
                2: set_registers(20'd4000, 20'd0);
                3: set_registers(20'd0, 20'h7FFF);
                default: set_registers(20'd2000, 20'd64);
            endcase
            send_gap_pct = (phase == 1) ? 56 : (phase == 3) ? 9 : (phase == 4) ? 1 : 0;
            recv_stall_pct = (phase == 2) ? 56 : (phase == 3) ? 9 : 0;
            repeat (PHASE_ITEMS) random_request();
        end
        recv_stall_pct = 0;

        drain();
        repeat (100) @(posedge aclk);
        $display("Covered allocation, calloc, free and idle requests over five register");
        $display("settings with sender gaps, receiver stalls and a long output hold-off.");
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
